// ----- rtl/omf_pkg.sv -----
package omf_pkg;

    // Request and response field widths.
    localparam int OP_W       = 2;
    localparam int VOL_W      = 64;
    localparam int SB_W       = 48;
    localparam int SNAP_W     = 31;
    localparam int BCNT_W     = 11;
    localparam int STATUS_W   = 2;
    localparam int OFFSET_W   = 48;
    localparam int XFER_W     = 23;
    localparam int OBJ_OUT_W  = 10;

    // Configuration register widths and reset values.
    localparam int CFG_W      = 41;
    localparam int META_W     = 41;
    localparam int OIU_W      = 11;
    localparam logic [META_W-1:0] META_RESET = META_W'(64'd16777216);
    localparam logic [OIU_W-1:0]  OIU_RESET  = OIU_W'(1024);

    // Default sizing; the chunk size and the object count are powers of two.
    localparam int DEF_MAX_OBJECTS  = 1024;
    localparam int DEF_OBJECT_ORDER = 22;
    localparam int DEF_BLOCK_ORDER  = 12;
    localparam int DEF_CHUNK_BLOCKS = 1024;

    // Register indexes.
    localparam logic CFG_METADATA = 1'b0;
    localparam logic CFG_OBJECTS  = 1'b1;

    // Opcodes.
    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [VOL_W-1:0]  volume_id;
        logic [SB_W-1:0]   start_block;
        logic [SNAP_W-1:0] snapshot_seq;
        logic [BCNT_W-1:0] block_count;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [OFFSET_W-1:0]  device_offset;
        logic [XFER_W-1:0]    transfer_bytes;
        logic [OBJ_OUT_W-1:0] object_index;
        logic                 newly_allocated;
    } rsp_t;

endpackage

// ----- rtl/omf_req_if.sv -----
interface omf_req_if;
    import omf_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/omf_rsp_if.sv -----
interface omf_rsp_if;
    import omf_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/object_map_with_free_list_unit.sv -----
// Requests are taken only in the idle state: the search token has to walk the whole chain
// of map cells, one cell per cycle, before a request can resolve, and a new request is
// accepted only after the response to the last one has been loaded.
// Reset (asynchronous, active low) clears every map valid bit, the fresh-object
// counter and the recycled FIFO pointers at once; no clearing pass is needed.
module object_map_with_free_list_unit #(
    parameter int MAX_OBJECTS  = omf_pkg::DEF_MAX_OBJECTS,
    parameter int OBJECT_ORDER = omf_pkg::DEF_OBJECT_ORDER,
    parameter int BLOCK_ORDER  = omf_pkg::DEF_BLOCK_ORDER,
    parameter int CHUNK_BLOCKS = omf_pkg::DEF_CHUNK_BLOCKS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [omf_pkg::CFG_W-1:0] cfg_data,
    omf_req_if.sink                   req,
    omf_rsp_if.source                 rsp
);
    import omf_pkg::*;

    localparam int IDX_W   = $clog2(MAX_OBJECTS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int CB_BITS = $clog2(CHUNK_BLOCKS);
    localparam int CHUNK_W = SB_W - CB_BITS;

    // The map key: volume, chunk number and snapshot.
    typedef struct packed {
        logic [VOL_W-1:0]   vol;
        logic [CHUNK_W-1:0] chunk;
        logic [SNAP_W-1:0]  snap;
    } key_t;

    // The search token that travels along the cell chain.
    typedef struct packed {
        logic             active;
        logic             hit;
        logic [IDX_W-1:0] hit_slot;
        logic [IDX_W-1:0] hit_obj;
        logic             empty_ok;
        logic [IDX_W-1:0] empty_slot;
    } tok_t;

    // Broadcast update of one map slot, insertion or removal.
    typedef struct packed {
        logic             en;
        logic             set;
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] obj;
    } upd_t;

    // One-hot controller states.
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_RESP   = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [META_W-1:0] meta_reg;
    logic [OIU_W-1:0]  oiu_reg;

    // Captured request.
    logic                launch_reg;
    logic [OP_W-1:0]     op_reg;
    key_t                key_reg;
    logic [CB_BITS-1:0]  bic_reg;
    logic [BCNT_W-1:0]   bcnt_reg;

    // Free-object allocator: fresh counter and recycled FIFO.
    logic [CNT_W-1:0] nf_reg, nf_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] fifo_mem [MAX_OBJECTS];
    logic [IDX_W-1:0] fifo_rd_reg;
    logic             push;
    logic [IDX_W-1:0] push_obj;
    logic             fresh_ok;

    // Resolved outcome, held for the offset stage.
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_obj_reg, res_obj_next;
    logic                res_fresh_reg, res_fresh_next;
    logic                res_off_reg, res_off_next;

    // Response register.
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_data_reg, rsp_data_next;

    // Cell chain.
    tok_t chain [MAX_OBJECTS+1];
    tok_t tok_last;
    upd_t upd;

    logic             accept;
    logic [OFFSET_W-1:0] offset;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // A new token enters the first cell in the cycle after acceptance.
    always_comb
    begin
        chain[0]        = '0;
        chain[0].active = launch_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_OBJECTS; gi++)
        begin : g_cell
            omf_cell #(
                .IDX   (gi),
                .IDX_W (IDX_W),
                .key_t (key_t),
                .tok_t (tok_t),
                .upd_t (upd_t)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .key     (key_reg),
                .upd     (upd),
                .tok_in  (chain[gi]),
                .tok_out (chain[gi+1])
            );
        end
    endgenerate

    assign tok_last = chain[MAX_OBJECTS];

    // A fresh index is available below the smaller of the configured count and the depth.
    assign fresh_ok = (32'(nf_reg) < 32'(oiu_reg)) && (32'(nf_reg) < MAX_OBJECTS);

    // Resolution happens in the cycle in which the token leaves the last cell. The map
    // update, the allocator update and the FIFO push all take effect at that edge.
    always_comb
    begin
        nf_next         = nf_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_obj_next    = res_obj_reg;
        res_fresh_next  = res_fresh_reg;
        res_off_next    = res_off_reg;
        upd             = '0;
        push            = 1'b0;
        push_obj        = tok_last.hit_obj;

        if (state_reg == S_SEARCH && tok_last.active)
        begin
            res_status_next = ST_OK;
            res_obj_next    = '0;
            res_fresh_next  = 1'b0;
            res_off_next    = 1'b0;
            unique case (op_reg)
                OP_READ:
                begin
                    if (tok_last.hit)
                    begin
                        res_obj_next = tok_last.hit_obj;
                        res_off_next = 1'b1;
                    end
                    else
                    begin
                        res_status_next = ST_NOTFOUND;
                    end
                end
                OP_WRITE:
                begin
                    if (tok_last.hit)
                    begin
                        res_obj_next = tok_last.hit_obj;
                        res_off_next = 1'b1;
                    end
                    else if (tok_last.empty_ok && (fresh_ok || count_reg != '0))
                    begin
                        if (fresh_ok)
                        begin
                            res_obj_next = IDX_W'(nf_reg);
                            nf_next      = nf_reg + 1'b1;
                        end
                        else
                        begin
                            res_obj_next = fifo_rd_reg;
                            head_next    = (32'(head_reg) == MAX_OBJECTS - 1) ?
                                           '0 : head_reg + 1'b1;
                            count_next   = count_reg - 1'b1;
                        end
                        upd.en         = 1'b1;
                        upd.set        = 1'b1;
                        upd.slot       = tok_last.empty_slot;
                        upd.obj        = res_obj_next;
                        res_off_next   = 1'b1;
                        res_fresh_next = 1'b1;
                    end
                    else
                    begin
                        res_status_next = ST_NOSPACE;
                    end
                end
                OP_DELETE:
                begin
                    if (tok_last.hit)
                    begin
                        upd.en       = 1'b1;
                        upd.set      = 1'b0;
                        upd.slot     = tok_last.hit_slot;
                        upd.obj      = tok_last.hit_obj;
                        res_obj_next = tok_last.hit_obj;
                        res_off_next = 1'b1;
                        // A full FIFO simply drops the freed index.
                        if (32'(count_reg) < MAX_OBJECTS)
                        begin
                            push       = 1'b1;
                            tail_next  = (32'(tail_reg) == MAX_OBJECTS - 1) ?
                                         '0 : tail_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    // Unused opcode: an OK response with zero offset and object index, no state change.
                end
            endcase
        end
    end

    // Byte offset on the device, taken modulo 2^48.
    assign offset = OFFSET_W'(meta_reg)
                  + (OFFSET_W'(res_obj_reg) << OBJECT_ORDER)
                  + (OFFSET_W'(bic_reg) << BLOCK_ORDER);

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (tok_last.active)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                // The response register is loaded once the previous response has gone.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next                = 1'b1;
                    rsp_data_next.status          = res_status_reg;
                    rsp_data_next.device_offset   = res_off_reg ? offset : '0;
                    rsp_data_next.transfer_bytes  = XFER_W'(32'(bcnt_reg) << BLOCK_ORDER);
                    rsp_data_next.object_index    = OBJ_OUT_W'(res_obj_reg);
                    rsp_data_next.newly_allocated = res_fresh_reg;
                    state_next                    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            meta_reg      <= META_RESET;
            oiu_reg       <= OIU_RESET;
            nf_reg        <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= accept;
            nf_reg        <= nf_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_METADATA: meta_reg <= META_W'(cfg_data);
                    CFG_OBJECTS:  oiu_reg  <= OIU_W'(cfg_data);
                    default:      meta_reg <= meta_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= req.data.opcode;
            key_reg.vol   <= req.data.volume_id;
            key_reg.chunk <= req.data.start_block[SB_W-1:CB_BITS];
            key_reg.snap  <= req.data.snapshot_seq;
            bic_reg       <= req.data.start_block[CB_BITS-1:0];
            bcnt_reg      <= req.data.block_count;
        end
        res_status_reg <= res_status_next;
        res_obj_reg    <= res_obj_next;
        res_fresh_reg  <= res_fresh_next;
        res_off_reg    <= res_off_next;
        rsp_data_reg   <= rsp_data_next;
    end

    // Recycled FIFO storage; the head entry is read every cycle into a register.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[tail_reg] <= push_obj;
        end
        fifo_rd_reg <= fifo_mem[head_reg];
    end
endmodule

// ----- rtl/omf_cell.sv -----
module omf_cell #(
    parameter int  IDX   = 0,
    parameter int  IDX_W = 10,
    parameter type key_t = logic,
    parameter type tok_t = logic,
    parameter type upd_t = logic
) (
    input  logic clk,
    input  logic rst_n,
    input  key_t key,
    input  upd_t upd,
    input  tok_t tok_in,
    output tok_t tok_out
);
    import omf_pkg::*;

    localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(IDX);

    logic             valid_reg;
    key_t             tag_reg;
    logic [IDX_W-1:0] obj_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic             match;
    logic             hit_me;

    assign match  = valid_reg && (tag_reg == key);
    assign hit_me = upd.en && (upd.slot == MY_SLOT);

    // The search token picks up the first matching slot and the first free slot.
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active)
        begin
            if (!tok_in.hit && match)
            begin
                tok_next.hit      = 1'b1;
                tok_next.hit_slot = MY_SLOT;
                tok_next.hit_obj  = obj_reg;
            end
            if (!tok_in.empty_ok && !valid_reg)
            begin
                tok_next.empty_ok   = 1'b1;
                tok_next.empty_slot = MY_SLOT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (hit_me)
            begin
                valid_reg <= upd.set;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_me && upd.set)
        begin
            tag_reg <= key;
            obj_reg <= upd.obj;
        end
    end

    assign tok_out = tok_reg;
endmodule
